// ===== rtl/pov_column_strobe_defines.svh =====
// Assertion macros shared by the column strobe checker.
// Depends on nothing; included by files that carry assertions.
`ifndef POV_COLUMN_STROBE_DEFINES_SVH
`define POV_COLUMN_STROBE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcs_pkg.sv =====
// Constants, register indexes and widths for the POV column strobe.
// No dependencies; used by pov_column_strobe.
package pcs_pkg;

  localparam int COLUMNS   = 8;
  localparam int LEDS      = 8;
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int HALF_SPAN = (COLUMNS - 1) / 2;

  localparam int TS_W      = 48;
  localparam int ANGLE_W   = 12;
  localparam int OFF_W     = 16;
  localparam int GLYPH_W   = 64;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 6;

  localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(TS_W - 1);
  localparam logic [ANGLE_W-1:0] FULL_TURN   = 12'd3600;
  localparam logic [12:0]        STALE_LIMIT = 13'd7200;
  localparam logic [BYTE_W-1:0]  LED_MASK    = BYTE_W'((16'd1 << LEDS) - 16'd1);

  localparam logic [ANGLE_W-1:0] PITCH_RESET = 12'd50;
  localparam logic [ANGLE_W-1:0] DRAW_RESET  = 12'd1800;
  localparam logic [GLYPH_W-1:0] GLYPH_RESET = 64'h0000_C366_3C66_C300;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_ANGLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BITS  = 2'd2;

  // Item kinds carried on tuser
  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

endpackage

// ===== rtl/pov_column_strobe.sv =====
// Column strobe for a spinning 8-LED persistence-of-vision disk.
// Depends on pcs_pkg; single module with a bit-serial restoring divider.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: timestamp; tuser: mode
//  m_axis    | out | m_axis_tvalid/tready    | tdata: led_column
//  cfg       | in  | cfg_wr_en (no wait)     | cfg_index, cfg_data
//
// A sensor edge runs only the divider: one quotient bit per cycle.
// A sample runs the divider, a range check, offset reduction, a scan of up to 8
// write positions and a load; a scan with no hit returns to idle with no result.
// A stale quotient loads a blank column through the load state after the range check.
// A zero rate skips the divider and loads a blank column through the load state.
// Results sit in an output register; the next item is taken while one waits,
// and a new result waits in the load cycle until that register is free.
// rst is synchronous and resets the state, control and configuration registers; datapath registers are not reset.
module pov_column_strobe (
  input  logic                         clk,
  input  logic                         rst,
  // input item stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pcs_pkg::TS_W-1:0]     s_axis_tdata,   // [47:0] timestamp
  input  logic                         s_axis_tuser,   // [0] mode
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pcs_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] led_column
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcs_pkg::GLYPH_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_OFFSET,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [pcs_pkg::ANGLE_W-1:0] pixel_pitch;
  logic [pcs_pkg::ANGLE_W-1:0] draw_angle;
  logic [pcs_pkg::GLYPH_W-1:0] glyph_bits;

  // architectural state
  logic [pcs_pkg::TS_W-1:0]    edge_time;
  logic [pcs_pkg::TS_W-1:0]    ticks_per_tenth;
  logic [pcs_pkg::ANGLE_W-1:0] previous_angle;

  // divider datapath
  logic [pcs_pkg::TS_W-1:0]    dvd;
  logic [pcs_pkg::TS_W-1:0]    rem;
  logic [pcs_pkg::TS_W-1:0]    dvs;
  logic [pcs_pkg::STEP_W-1:0]  step;
  logic                        is_sample;

  // angle and column scan
  logic [pcs_pkg::ANGLE_W-1:0] angle;
  logic [pcs_pkg::ANGLE_W-1:0] draw_m;
  logic [pcs_pkg::ANGLE_W-1:0] pitch_m;
  logic [pcs_pkg::OFF_W-1:0]   offset;
  logic [pcs_pkg::ANGLE_W-1:0] pos;
  logic [pcs_pkg::COL_W-1:0]   col;
  logic [pcs_pkg::GLYPH_W-1:0] glyph_sh;
  logic [pcs_pkg::BYTE_W-1:0]  col_val;

  logic                        s_xfer;
  logic                        m_xfer;
  logic                        m_free;
  logic [pcs_pkg::TS_W-1:0]    elapsed;
  logic [pcs_pkg::TS_W+1:0]    trial;
  logic                        q_bit;
  logic [pcs_pkg::TS_W-1:0]    rem_next;
  logic [pcs_pkg::TS_W-1:0]    dvd_next;
  logic                        stale;
  logic [12:0]                 q_low;
  logic [pcs_pkg::ANGLE_W-1:0] angle_next;
  logic [pcs_pkg::OFF_W-1:0]   offset_init;
  logic [12:0]                 start_sum;
  logic [pcs_pkg::ANGLE_W-1:0] first_pos;
  logic [12:0]                 pos_sum;
  logic [pcs_pkg::ANGLE_W-1:0] pos_next;
  logic                        hit;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  assign m_free        = !m_axis_tvalid || m_axis_tready;

  // time since the last sensor edge, modulo 2^48
  assign elapsed = s_axis_tdata - edge_time;

  // one restoring divide step: shift in the next dividend bit, try a subtract
  always_comb begin
    trial    = {1'b0, rem, dvd[pcs_pkg::TS_W-1]} - {2'b00, dvs};
    q_bit    = !trial[pcs_pkg::TS_W+1];
    rem_next = q_bit ? trial[pcs_pkg::TS_W-1:0]
                     : {rem[pcs_pkg::TS_W-2:0], dvd[pcs_pkg::TS_W-1]};
    dvd_next = {dvd[pcs_pkg::TS_W-2:0], q_bit};
  end

  // range check and angle reduction on the finished quotient
  always_comb begin
    stale = (dvd > pcs_pkg::TS_W'(pcs_pkg::STALE_LIMIT));
    q_low = dvd[12:0];
    if (q_low >= pcs_pkg::STALE_LIMIT) begin
      angle_next = pcs_pkg::ANGLE_W'(q_low - pcs_pkg::STALE_LIMIT);
    end else if (q_low >= 13'(pcs_pkg::FULL_TURN)) begin
      angle_next = pcs_pkg::ANGLE_W'(q_low - 13'(pcs_pkg::FULL_TURN));
    end else begin
      angle_next = q_low[pcs_pkg::ANGLE_W-1:0];
    end
    // half a pitch plus whole pitches to the left of centre
    offset_init = pcs_pkg::OFF_W'(pixel_pitch >> 1)
                + pcs_pkg::OFF_W'(pcs_pkg::HALF_SPAN) * pcs_pkg::OFF_W'(pixel_pitch);
  end

  // first write position and the step to the next one
  always_comb begin
    start_sum = 13'(draw_m) + 13'(pcs_pkg::FULL_TURN) - 13'(offset[pcs_pkg::ANGLE_W-1:0]);
    first_pos = (start_sum >= 13'(pcs_pkg::FULL_TURN))
              ? pcs_pkg::ANGLE_W'(start_sum - 13'(pcs_pkg::FULL_TURN))
              : start_sum[pcs_pkg::ANGLE_W-1:0];
    pos_sum   = 13'(pos) + 13'(pitch_m);
    pos_next  = (pos_sum >= 13'(pcs_pkg::FULL_TURN))
              ? pcs_pkg::ANGLE_W'(pos_sum - 13'(pcs_pkg::FULL_TURN))
              : pos_sum[pcs_pkg::ANGLE_W-1:0];
    hit       = (previous_angle < pos) && (angle >= pos);
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_axis_tvalid   <= 1'b0;
      pixel_pitch     <= pcs_pkg::PITCH_RESET;
      draw_angle      <= pcs_pkg::DRAW_RESET;
      glyph_bits      <= pcs_pkg::GLYPH_RESET;
      edge_time       <= '0;
      ticks_per_tenth <= '1;
      previous_angle  <= '0;
      step            <= '0;
      is_sample       <= 1'b0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          pcs_pkg::REG_PIXEL_PITCH: pixel_pitch <= cfg_data[pcs_pkg::ANGLE_W-1:0];
          pcs_pkg::REG_DRAW_ANGLE:  draw_angle  <= cfg_data[pcs_pkg::ANGLE_W-1:0];
          pcs_pkg::REG_GLYPH_BITS:  glyph_bits  <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once transferred, unless a new one loads this cycle
      if (m_xfer && state != ST_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            dvd       <= elapsed;
            rem       <= '0;
            step      <= '0;
            is_sample <= (s_axis_tuser == pcs_pkg::MODE_SAMPLE);
            if (s_axis_tuser == pcs_pkg::MODE_EDGE) begin
              dvs       <= pcs_pkg::TS_W'(pcs_pkg::FULL_TURN);
              edge_time <= s_axis_tdata;
              state     <= ST_DIVIDE;
            end else if (ticks_per_tenth == '0) begin
              col_val <= '0;
              state   <= ST_EMIT;
            end else begin
              dvs   <= ticks_per_tenth;
              state <= ST_DIVIDE;
            end
          end
        end

        ST_DIVIDE: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == pcs_pkg::DIV_LAST) begin
            if (is_sample) begin
              state <= ST_CHECK;
            end else begin
              ticks_per_tenth <= dvd_next;
              state           <= ST_IDLE;
            end
          end
        end

        ST_CHECK: begin
          if (stale) begin
            col_val <= '0;
            state   <= ST_EMIT;
          end else begin
            angle   <= angle_next;
            offset  <= offset_init;
            draw_m  <= (draw_angle >= pcs_pkg::FULL_TURN)
                     ? draw_angle - pcs_pkg::FULL_TURN : draw_angle;
            pitch_m <= (pixel_pitch >= pcs_pkg::FULL_TURN)
                     ? pixel_pitch - pcs_pkg::FULL_TURN : pixel_pitch;
            state   <= ST_OFFSET;
          end
        end

        // reduce the offset one full turn per cycle
        ST_OFFSET: begin
          if (offset >= pcs_pkg::OFF_W'(pcs_pkg::FULL_TURN)) begin
            offset <= offset - pcs_pkg::OFF_W'(pcs_pkg::FULL_TURN);
          end else begin
            pos      <= first_pos;
            col      <= '0;
            glyph_sh <= glyph_bits;
            state    <= ST_SCAN;
          end
        end

        // test one write position per cycle, glyph shifting a column at a time
        ST_SCAN: begin
          if (hit) begin
            col_val        <= glyph_sh[pcs_pkg::BYTE_W-1:0] & pcs_pkg::LED_MASK;
            previous_angle <= angle;
            state          <= ST_EMIT;
          end else if (col == pcs_pkg::COL_W'(pcs_pkg::COLUMNS - 1)) begin
            previous_angle <= angle;
            state          <= ST_IDLE;
          end else begin
            pos      <= pos_next;
            col      <= col + 1'b1;
            glyph_sh <= glyph_sh >> pcs_pkg::BYTE_W;
          end
        end

        // hold until the output register is free
        ST_EMIT: begin
          if (m_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= col_val;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pcs_checker.sv =====
// Port-level checks for pov_column_strobe, bound to the top level.
// Depends on pov_column_strobe_defines.svh for the assertion macros.
`include "pov_column_strobe_defines.svh"

module pcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // an accepted item keeps the input closed for the next cycle
  `PCS_ASSERT_NEXT(a_busy_after_accept, s_xfer, !s_axis_tready, "input reopened too early")

  // a sensor edge never raises a result while the divider runs
  `PCS_ASSERT_NEXT(a_edge_silent, s_xfer && !s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "result after sensor edge")

  // a new result only appears out of a busy cycle
  `PCS_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result while idle")

  // a stalled result holds
  `PCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind pov_column_strobe pcs_checker u_pcs_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pov_column_strobe: stream stimulus, random idling,
// config phases and a column predictor. Depends on pcs_pkg and the block's RTL.
module tb_top;
  import pcs_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 4000;
  localparam int                   SETTLE_CYCLES  = 80;
  localparam int                   PHASES         = 10;
  localparam int                   PHASE_ITEMS    = 140;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;

  // Predicts the LED column for each accepted item and holds the columns
  // still owed by the block, oldest first.
  class strobe_scoreboard;
    bit [ANGLE_W-1:0] pitch;
    bit [ANGLE_W-1:0] draw;
    bit [GLYPH_W-1:0] glyph;
    bit [TS_W-1:0]    edge_time;
    bit [TS_W-1:0]    ticks_per_tenth;
    bit [ANGLE_W-1:0] prev_angle;
    bit [BYTE_W-1:0]  owed_columns[$];
    int               errors;

    function new();
      pitch           = PITCH_RESET;
      draw            = DRAW_RESET;
      glyph           = GLYPH_RESET;
      edge_time       = '0;
      ticks_per_tenth = '1;
      prev_angle      = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GLYPH_W-1:0] value);
      case (idx)
        REG_PIXEL_PITCH: pitch = value[ANGLE_W-1:0];
        REG_DRAW_ANGLE:  draw  = value[ANGLE_W-1:0];
        REG_GLYPH_BITS:  glyph = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_columns.size();
    endfunction

    // Advance the disk state for one transfer and queue any column it owes
    function void note_input(logic mode, logic [TS_W-1:0] ts);
      bit [TS_W-1:0] elapsed;
      bit [63:0]     turn;
      bit [63:0]     quotient;
      bit [63:0]     p;
      bit [63:0]     offset;
      bit [63:0]     start;
      bit [63:0]     pos;
      bit [63:0]     angle;
      bit            hit;
      turn    = FULL_TURN;
      elapsed = ts - edge_time;
      if (mode == MODE_EDGE) begin
        ticks_per_tenth = elapsed / turn;
        edge_time       = ts;
      end else if (ticks_per_tenth == '0) begin
        owed_columns.push_back('0);
      end else begin
        quotient = elapsed / ticks_per_tenth;
        if (quotient > STALE_LIMIT) begin
          owed_columns.push_back('0);
        end else begin
          angle  = quotient % turn;
          p      = pitch;
          offset = p / 2 + HALF_SPAN * p;
          start  = ((draw % turn) + turn - (offset % turn)) % turn;
          hit    = 1'b0;
          for (int c = 0; c < COLUMNS; c++) begin
            pos = (start + c * (p % turn)) % turn;
            if (!hit && prev_angle < pos && angle >= pos) begin
              owed_columns.push_back(glyph[8*c +: 8] & LED_MASK);
              hit = 1'b1;
            end
          end
          prev_angle = angle[ANGLE_W-1:0];
        end
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] got);
      bit [BYTE_W-1:0] want;
      if (owed_columns.size() == 0) begin
        $error("led_column: unexpected transfer, expected none, actual %02h", got);
        errors++;
      end else begin
        want = owed_columns.pop_front();
        if (want !== got) begin
          $error("led_column mismatch: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TS_W-1:0]      s_axis_tdata;    // [47:0] timestamp
  logic                 s_axis_tuser;    // [0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [BYTE_W-1:0]    m_axis_tdata;    // [7:0] led_column
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GLYPH_W-1:0]   cfg_data;

  strobe_scoreboard sb;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               quiet_cycles;

  pov_column_strobe u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [63:0] rand_below(bit [63:0] n);
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r % n;
  endfunction

  function automatic bit [TS_W-1:0] rand_ts();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[TS_W-1:0];
  endfunction

  // Revolution period in ticks: mostly steady rates, some too fast to
  // measure and a few close to the counter range
  function automatic bit [63:0] pick_period();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom_range(1, 3599);
    if (sel == 1) return rand_below(64'd1 << 47) + 1;
    return 64'd3600 * $urandom_range(1, 4000) + $urandom_range(0, 3599);
  endfunction

  // Present one item, holding it until the block takes the transfer
  task automatic send_item(input logic mode, input logic [TS_W-1:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= ts;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(mode, ts);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GLYPH_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_config(input logic [ANGLE_W-1:0] pitch, input logic [ANGLE_W-1:0] draw,
                             input logic [GLYPH_W-1:0] glyph, input bit poke_spare);
    write_reg(REG_PIXEL_PITCH, {52'd0, pitch});
    write_reg(REG_DRAW_ANGLE, {52'd0, draw});
    write_reg(REG_GLYPH_BITS, glyph);
    if (poke_spare) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid, wait for every owed column, then let an item with no
  // result finish inside the block
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Revolutions: an edge, a handful of samples spread over up to two
  // periods, then the next edge; some stray items and rate changes mixed in
  task automatic run_phase(input int n_items);
    bit [TS_W-1:0] edge_ts;
    bit [63:0]     period;
    bit [63:0]     next_period;
    bit [63:0]     off;
    int            sent;
    int            n;
    period  = pick_period();
    edge_ts = $urandom_range(0, 1) ? rand_ts() : ('1 - TS_W'(rand_below(64'd1 << 26)));
    send_item(MODE_EDGE, edge_ts);
    sent = 1;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(logic'($urandom_range(0, 1)), rand_ts());
        sent++;
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          next_period = pick_period();
        end else begin
          next_period = period + rand_below(period / 50 + 1) - period / 100;
        end
        n   = $urandom_range(1, 10);
        off = 0;
        for (int k = 0; k < n; k++) begin
          off += rand_below(2 * period / n + 1);
          send_item(MODE_SAMPLE, edge_ts + off[TS_W-1:0]);
          sent++;
        end
        edge_ts += next_period[TS_W-1:0];
        send_item(MODE_EDGE, edge_ts);
        sent++;
        period = next_period;
      end
    end
  endtask

  // Result side: check each transfer, stall at random, watch for a hang
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    bit [TS_W-1:0] t;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_EDGE;
    m_axis_tready <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_PIXEL_PITCH;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: samples against the reset rate, timestamp extremes
    send_item(MODE_SAMPLE, '0);
    send_item(MODE_SAMPLE, '1);
    // Period under a full turn of tenths gives a zero rate
    send_item(MODE_EDGE, 48'd1000);
    send_item(MODE_SAMPLE, 48'd2000);
    // Rate of 100 ticks per tenth; walk the angle across the columns
    t = 48'd361000;
    send_item(MODE_EDGE, t);
    send_item(MODE_SAMPLE, t + 48'd170000);
    send_item(MODE_SAMPLE, t + 48'd168000);
    send_item(MODE_SAMPLE, t + 48'd198000);
    send_item(MODE_SAMPLE, t + 48'd359900);
    // Quotient at the stale limit wraps to zero; one past it is stale
    send_item(MODE_SAMPLE, t + 48'd720000);
    send_item(MODE_SAMPLE, t + 48'd720100);
    send_item(MODE_SAMPLE, t + 48'd540000);
    // Edges straddling the counter wrap
    t = 48'hFFFF_FFFF_F000;
    send_item(MODE_EDGE, t);
    t = t + 48'd25200;
    send_item(MODE_EDGE, t);
    send_item(MODE_SAMPLE, t + 48'd11550);
    send_item(MODE_SAMPLE, t + 48'd21000);
    // Repeated edge time, then the longest measurable period
    send_item(MODE_EDGE, t);
    send_item(MODE_SAMPLE, t + 48'd5);
    send_item(MODE_EDGE, t - 48'd1);
    send_item(MODE_SAMPLE, t - 48'd2);
    send_item(MODE_SAMPLE, t + 48'd7);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (ph)
        0: load_config(12'd1, 12'd0, {$urandom, $urandom}, 1'b0);
        1: load_config(12'd3600, 12'd3599, '1, 1'b0);
        2: load_config(12'd0, 12'd4095, '0, 1'b1);
        3: load_config(12'd4095, 12'($urandom_range(0, 4095)), {$urandom, $urandom}, 1'b0);
        4: load_config(PITCH_RESET, DRAW_RESET, GLYPH_RESET, 1'b0);
        default: load_config(12'($urandom_range(0, 3) == 0 ? $urandom_range(1, 3600)
                                                           : $urandom_range(1, 450)),
                             12'($urandom_range(0, 3599)), {$urandom, $urandom}, 1'b0);
      endcase
      run_phase(PHASE_ITEMS);
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pov_column_strobe.sv
rtl/pcs_checker.sv
dv/tb_top.sv
